>>> design/bpa_pkg.sv
// Package with the shared request/response types and constants of the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int ADDR_W             = 56;
   localparam int COUNT_W            = 16;
   localparam int WANT_W             = COUNT_W + 1;
   localparam int STATUS_W           = 2;
   localparam int PAGES_DEFAULT      = 4096;
   localparam int PAGE_BYTES_DEFAULT = 4096;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE_SPLT = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [COUNT_W-1:0] page_count;
      logic [ADDR_W-1:0]  phys_addr;
   } bpa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   phys_addr_res;
   } bpa_rsp_type;

endpackage

>>> design/buddy_page_allocator_core.sv
// Buddy page allocator: node tree in a memory with one read and one write port, walked by a small sequencer.
//
//   channel   direction  handshake                     payload
//   request   in         start && !busy                req_data (bpa_req_type)
//   response  out        rsp_valid, one cycle          rsp_data (bpa_rsp_type)
//   csr       in/out     psel && penable, pready high  base_address at byte 0
//
// After reset a clearing pass writes every node with its full size, with busy high.
// Allocate rounds the count up to a power of two, reads and evaluates each node
// visited by the depth-first search, steps back from a failed subtree, updates the
// ancestors on the way back up to the root, and forms the address with a multiply
// and an add. Free checks the range, divides by the page size through a reciprocal,
// climbs from the leaf to find the node, descends through split nodes and merges
// buddies level by level. All node accesses go through one read port and one
// write port of the memory. The response cannot be stalled.
`timescale 1ns / 1ps

module buddy_page_allocator_core #(
   parameter int PAGES      = bpa_pkg::PAGES_DEFAULT,
   parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bpa_pkg::bpa_req_type  req_data,
   output logic                  rsp_valid,
   output bpa_pkg::bpa_rsp_type  rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   import bpa_pkg::*;

   localparam int LP    = $clog2(PAGES);
   localparam int NW    = LP + 1;
   localparam int SW    = LP + 1;
   localparam int EW    = SW + 1;
   localparam int DEPTH = 2 * PAGES;
   localparam int PBW   = $clog2(PAGE_BYTES + 1);
   localparam logic [63:0] POOL_BYTES = 64'(PAGES) * 64'(PAGE_BYTES);
   localparam int RW    = $clog2(POOL_BYTES);
   localparam int DW    = RW + 1;
   // Reciprocal of the page size, exact for every dividend below 2**RW.
   localparam int QS    = RW + $clog2(PAGE_BYTES);
   localparam int PW    = 2 * RW + 2;
   localparam logic [63:0] RECIP = ((64'd1 << QS) + 64'(PAGE_BYTES) - 64'd1) /
                                   64'(PAGE_BYTES);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ROUND, S_VRD, S_VEV, S_BACK, S_URD, S_UEV, S_AMUL, S_AADD,
      S_FCHK, S_DIV, S_FLEAF, S_FUP, S_DRD, S_DEV, S_MSRD, S_MSEV, S_MPEV
   } state_type;

   state_type         state_ff, state_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [SW-1:0]     blk_ff, blk_in;
   logic [LP-1:0]     off_ff, off_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [EW-1:0]     cur_ff, cur_in;
   logic [EW-1:0]     pend_ff, pend_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [LP+PBW-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type       rsp_ff, rsp_in;

   logic [EW-1:0]     tree_mem [DEPTH];
   logic [EW-1:0]     rd_data_ff;
   logic [NW-1:0]     rd_addr;
   logic              wr_en;
   logic [NW-1:0]     wr_addr;
   logic [EW-1:0]     wr_data;

   logic [SW-1:0]     rd_size, cur_size, big_size;
   logic              rd_split;
   logic [ADDR_W:0]   diff;
   logic [PW-1:0]     div_prod;

   assign rd_size  = rd_data_ff[SW-1:0];
   assign rd_split = rd_data_ff[EW-1];
   assign cur_size = cur_ff[SW-1:0];
   assign big_size = (cur_size > rd_size) ? cur_size : rd_size;
   assign diff     = {1'b0, addr_ff} - {1'b0, base_ff};
   assign div_prod = PW'(rem_ff) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      blk_in       = blk_ff;
      off_in       = off_ff;
      want_in      = want_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;

      if (psel && penable && pwrite && !paddr[3]) begin
         base_in = pwdata[ADDR_W-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = {1'b0, blk_ff};
            node_in = node_ff + NW'(1);
            // Each new level starts at a power of two and holds half the block size.
            if ((node_in & node_ff) == '0) begin
               blk_in = blk_ff >> 1;
            end
            if (node_ff == NW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               want_in = WANT_W'(1);
               cnt_in  = req_data.page_count;
               addr_in = req_data.phys_addr;
               state_in = (req_data.req_type == REQ_FREE) ? S_FCHK : S_ROUND;
            end
         end
         S_ROUND: begin
            if (want_ff < WANT_W'(cnt_ff)) begin
               want_in = want_ff << 1;
            end else if (want_ff > WANT_W'(PAGES)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_NO_SPACE, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else begin
               node_in  = NW'(1);
               blk_in   = SW'(PAGES);
               off_in   = '0;
               state_in = S_VRD;
            end
         end
         S_VRD: begin
            rd_addr  = node_ff;
            state_in = S_VEV;
         end
         S_VEV: begin
            if (WANT_W'(rd_size) < want_ff) begin
               state_in = S_BACK;
            end else if (WANT_W'(rd_size) == want_ff && !rd_split) begin
               wr_en    = 1'b1;
               wr_data  = '0;
               cur_in   = '0;
               state_in = S_URD;
            end else if (node_ff >= NW'(PAGES)) begin
               state_in = S_BACK;
            end else begin
               node_in  = node_ff << 1;
               blk_in   = blk_ff >> 1;
               state_in = S_VRD;
            end
         end
         S_BACK: begin
            // The subtree at node_ff has failed; try its right buddy or climb.
            if (node_ff == NW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_NO_SPACE, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else if (!node_ff[0]) begin
               node_in  = node_ff + NW'(1);
               off_in   = LP'(SW'(off_ff) + blk_ff);
               state_in = S_VRD;
            end else begin
               node_in = node_ff >> 1;
               off_in  = LP'(SW'(off_ff) - blk_ff);
               blk_in  = blk_ff << 1;
            end
         end
         S_URD: begin
            rd_addr = node_ff ^ NW'(1);
            state_in = (node_ff == NW'(1)) ? S_AMUL : S_UEV;
         end
         S_UEV: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff >> 1;
            wr_data  = {1'b1, big_size};
            cur_in   = {1'b1, big_size};
            node_in  = node_ff >> 1;
            state_in = S_URD;
         end
         S_AMUL: begin
            prod_in  = (LP+PBW)'(off_ff) * (LP+PBW)'(PAGE_BYTES);
            state_in = S_AADD;
         end
         S_AADD: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STATUS_OK,
                             phys_addr_res: base_ff + ADDR_W'(prod_ff)};
            state_in     = S_IDLE;
         end
         S_FCHK: begin
            if (diff[ADDR_W] || diff[ADDR_W-1:0] >= ADDR_W'(POOL_BYTES)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_BAD_ADDR, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else begin
               rem_in   = DW'(diff[ADDR_W-1:0]);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Division by the page size as a multiplication by its reciprocal.
            off_in   = LP'(div_prod >> QS);
            state_in = S_FLEAF;
         end
         S_FLEAF: begin
            node_in  = NW'(PAGES) + NW'(off_ff);
            blk_in   = SW'(1);
            state_in = S_FUP;
         end
         S_FUP: begin
            // Climb from the leaf while it is a left child to reach the top aligned node.
            if (!node_ff[0]) begin
               node_in = node_ff >> 1;
               blk_in  = blk_ff << 1;
            end else begin
               state_in = S_DRD;
            end
         end
         S_DRD: begin
            rd_addr  = node_ff;
            state_in = S_DEV;
         end
         S_DEV: begin
            if (rd_split && node_ff < NW'(PAGES)) begin
               node_in  = node_ff << 1;
               blk_in   = blk_ff >> 1;
               state_in = S_DRD;
            end else if (rd_split) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_FREE_SPLT, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else begin
               wr_en    = 1'b1;
               wr_data  = {1'b0, blk_ff};
               cur_in   = {1'b0, blk_ff};
               state_in = S_MSRD;
            end
         end
         S_MSRD: begin
            rd_addr = node_ff ^ NW'(1);
            if (node_ff == NW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_OK, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_MSEV;
            end
         end
         S_MSEV: begin
            rd_addr = node_ff >> 1;
            if (cur_ff == rd_data_ff && !cur_ff[EW-1]) begin
               wr_en    = 1'b1;
               wr_addr  = node_ff >> 1;
               wr_data  = {1'b0, SW'(cur_size + rd_size)};
               cur_in   = {1'b0, SW'(cur_size + rd_size)};
               node_in  = node_ff >> 1;
               state_in = S_MSRD;
            end else begin
               pend_in  = {1'b1, big_size};
               state_in = S_MPEV;
            end
         end
         S_MPEV: begin
            // The parent was read in the previous cycle; stop once it no longer changes.
            wr_en   = 1'b1;
            wr_addr = node_ff >> 1;
            wr_data = pend_ff;
            cur_in  = pend_ff;
            node_in = node_ff >> 1;
            if (rd_data_ff == pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_OK, phys_addr_res: '0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_MSRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         node_ff      <= NW'(1);
         blk_ff       <= SW'(PAGES);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         blk_ff       <= blk_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff  <= off_in;
      want_ff <= want_in;
      cnt_ff  <= cnt_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[3] ? 64'd0 : 64'(base_ff);

endmodule
